// ===== rtl/pf_pkg.sv =====
`timescale 1ns / 1ps

package pf_pkg;

  // Trial division starts at the smallest prime.
  localparam int FIRST_DIV = 2;

  typedef struct packed {
    logic load;
    logic div_start;
    logic advance;
    logic emit_div;
    logic emit_rest;
  } pf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rest_zero;
    logic rest_one;
    logic loop_exit;
    logic rem_zero;
    logic rest_big;
    logic last_div;
    logic out_free;
  } pf_status_t;

endpackage

// ===== rtl/pf_number_if.sv =====
`timescale 1ns / 1ps

interface pf_number_if #(
  parameter int NUMBER_WIDTH = 31
);
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

// ===== rtl/pf_factor_if.sv =====
`timescale 1ns / 1ps

interface pf_factor_if #(
  parameter int NUMBER_WIDTH = 31
);
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] factor;
  logic                    last;

  modport source (output valid, output factor, output last, input ready);
  modport sink (input valid, input factor, input last, output ready);
endinterface

// ===== rtl/pf_divider.sv =====
`timescale 1ns / 1ps

module pf_divider #(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NUMBER_WIDTH-1:0] dividend_i,
  input  logic [NUMBER_WIDTH-1:0] divisor_i,
  output logic                    done_o,
  output logic [NUMBER_WIDTH-1:0] quotient_o,
  output logic [NUMBER_WIDTH-1:0] remainder_o
);

  localparam int W    = NUMBER_WIDTH;
  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [W:0]      trial;
  logic [W:0]      diff;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    diff  = trial - {1'b0, dvs_q};
    if (!diff[W]) begin
      rem_d = diff[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b1};
    end else begin
      rem_d = trial[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== rtl/pf_datapath.sv =====
`timescale 1ns / 1ps

module pf_datapath #(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pf_pkg::pf_cmd_t         cmd_i,
  output pf_pkg::pf_status_t      status_o,
  input  logic [NUMBER_WIDTH-1:0] number_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [NUMBER_WIDTH-1:0] factor_o,
  output logic                    last_o
);
  import pf_pkg::*;

  localparam int W    = NUMBER_WIDTH;
  localparam int CntW = $clog2(W);
  localparam logic [CntW-1:0] Limit = CntW'(W - 1);

  logic [W-1:0]    rest_q;
  logic [W-1:0]    div_q;
  logic [CntW-1:0] count_q;
  logic [W-1:0]    factor_q;
  logic            last_q;
  logic            out_valid_q;
  logic            div_done;
  logic [W-1:0]    quot;
  logic [W-1:0]    rem;
  logic            at_limit;
  logic            out_free;

  pf_divider #(
    .NUMBER_WIDTH(W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rest_q),
    .divisor_i  (div_q),
    .done_o     (div_done),
    .quotient_o (quot),
    .remainder_o(rem)
  );

  assign at_limit = (count_q == Limit);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.div_done  = div_done;
    status_o.rest_zero = (rest_q == '0);
    status_o.rest_one  = (rest_q == W'(1));
    // The divisor has passed the square root once it exceeds the quotient.
    status_o.loop_exit = (div_q > quot) || at_limit;
    status_o.rem_zero  = (rem == '0);
    status_o.rest_big  = (rest_q > W'(1)) && !at_limit;
    // Any quotient above one yields at least one more factor, unless this factor reaches the count limit.
    status_o.last_div  = (quot == W'(1)) || ((count_q + 1'b1) == Limit);
    status_o.out_free  = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rest_q  <= number_i;
      div_q   <= W'(FIRST_DIV);
      count_q <= '0;
    end else if (cmd_i.advance) begin
      // Even divisors past two never divide, so they are skipped.
      div_q <= (div_q == W'(FIRST_DIV)) ? W'(3) : div_q + W'(2);
    end else if (cmd_i.emit_div) begin
      rest_q  <= quot;
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_div) begin
      factor_q <= div_q;
      last_q   <= (quot == W'(1)) || ((count_q + 1'b1) == Limit);
    end else if (cmd_i.emit_rest) begin
      factor_q <= rest_q;
      last_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_div || cmd_i.emit_rest) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign factor_o    = factor_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/pf_controller.sv =====
`timescale 1ns / 1ps

module pf_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pf_pkg::pf_status_t status_i,
  output pf_pkg::pf_cmd_t    cmd_o
);
  import pf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_START,
    S_WAIT,
    S_DECIDE,
    S_EMIT_DIV,
    S_EMIT_REST
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_start = (state_q == S_START);
    cmd_o.advance   = (state_q == S_DECIDE) && !status_i.loop_exit && !status_i.rem_zero;
    cmd_o.emit_div  = (state_q == S_EMIT_DIV) && status_i.out_free;
    cmd_o.emit_rest = (state_q == S_EMIT_REST) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_CHECK;
        end
        S_CHECK: begin
          // A zero gives no result; a one is sent as its own last factor.
          if (status_i.rest_zero) state_q <= S_IDLE;
          else if (status_i.rest_one) state_q <= S_EMIT_REST;
          else state_q <= S_START;
        end
        S_START: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (status_i.div_done) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (status_i.loop_exit) begin
            state_q <= status_i.rest_big ? S_EMIT_REST : S_IDLE;
          end else if (status_i.rem_zero) begin
            state_q <= S_EMIT_DIV;
          end else begin
            state_q <= S_START;
          end
        end
        S_EMIT_DIV: begin
          if (status_i.out_free) state_q <= status_i.last_div ? S_IDLE : S_START;
        end
        S_EMIT_REST: begin
          if (status_i.out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/prime_factorizer.sv =====
`timescale 1ns / 1ps
// Factors one number at a time; a new request is taken only when the controller is idle.
// Each trial division runs in the shared bit-serial divider.
// Divisors tried are 2 and then odd values up to the square root of the remainder,
// so a prime near 2^31 takes about 23200 trials.
// Each factor found passes through an emit state, plus any wait on the output register.
// Reset clears the controller and the output valid flag; no clearing pass is needed.

module prime_factorizer #(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pf_number_if.sink   number_i,
  pf_factor_if.source factor_o
);
  import pf_pkg::*;

  pf_cmd_t    cmd;
  pf_status_t status;

  pf_controller u_controller (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(number_i.valid),
    .in_ready_o(number_i.ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pf_datapath #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .number_i   (number_i.number),
    .out_ready_i(factor_o.ready),
    .out_valid_o(factor_o.valid),
    .factor_o   (factor_o.factor),
    .last_o     (factor_o.last)
  );

endmodule
